### design/dd_pkg.sv
`default_nettype none

package dd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 23;
  localparam int DN_W    = 22;
  localparam int DOY_W   = 9;
  localparam int Q_W     = 8;

  localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

  localparam int RECIP_W     = 13;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

  localparam logic [DN_W-1:0] DAYS_PER_YEAR = DN_W'(365);
  localparam logic [YEAR_W-1:0] CENTURY = YEAR_W'(100);
  localparam logic [MONTH_W-1:0] MARCH = MONTH_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_SUM_A,
    ST_MUL_B,
    ST_SUM_B,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic push;
    logic second;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_ready;
  } sts_t;

  // days in the months before month m, common year
  function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd0, 4'd1: r = DOY_W'(0);
      4'd2:       r = DOY_W'(31);
      4'd3:       r = DOY_W'(59);
      4'd4:       r = DOY_W'(90);
      4'd5:       r = DOY_W'(120);
      4'd6:       r = DOY_W'(151);
      4'd7:       r = DOY_W'(181);
      4'd8:       r = DOY_W'(212);
      4'd9:       r = DOY_W'(243);
      4'd10:      r = DOY_W'(273);
      4'd11:      r = DOY_W'(304);
      4'd12:      r = DOY_W'(334);
      default:    r = DOY_W'(365);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### design/dd_in_if.sv
`default_nettype none

interface dd_in_if;
  logic                        valid;
  logic                        ready;
  logic [dd_pkg::YEAR_W-1:0]  first_year;
  logic [dd_pkg::MONTH_W-1:0] first_month;
  logic [dd_pkg::DAY_W-1:0]   first_day;
  logic [dd_pkg::YEAR_W-1:0]  second_year;
  logic [dd_pkg::MONTH_W-1:0] second_month;
  logic [dd_pkg::DAY_W-1:0]   second_day;

  modport source (
    output valid, first_year, first_month, first_day,
           second_year, second_month, second_day,
    input  ready
  );

  modport sink (
    input  valid, first_year, first_month, first_day,
           second_year, second_month, second_day,
    output ready
  );
endinterface

`default_nettype wire

### design/dd_out_if.sv
`default_nettype none

interface dd_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dd_pkg::DIFF_W-1:0] day_difference;

  modport source (output valid, day_difference, input ready);
  modport sink (input valid, day_difference, output ready);
endinterface

`default_nettype wire

### design/dd_datapath.sv
`default_nettype none

module dd_datapath (
  input  wire                               clk,
  input  dd_pkg::cmd_t                      cmd,
  input  wire [dd_pkg::YEAR_W-1:0]          first_year,
  input  wire [dd_pkg::MONTH_W-1:0]         first_month,
  input  wire [dd_pkg::DAY_W-1:0]           first_day,
  input  wire [dd_pkg::YEAR_W-1:0]          second_year,
  input  wire [dd_pkg::MONTH_W-1:0]         second_month,
  input  wire [dd_pkg::DAY_W-1:0]           second_day,
  output logic signed [dd_pkg::DIFF_W-1:0]  day_difference
);
  import dd_pkg::*;

  logic [YEAR_W-1:0]  yr_a, yr_b;
  logic [MONTH_W-1:0] mo_a, mo_b;
  logic [DAY_W-1:0]   dy_a, dy_b;
  logic [PROD_W-1:0]  prod;
  logic [DN_W-1:0]    base;
  logic [DN_W-1:0]    dn_a, dn_b;

  logic [YEAR_W-1:0]  y;
  logic [MONTH_W-1:0] m;
  logic [DAY_W-1:0]   d;
  logic [YEAR_W:0]    y_p3;
  logic [Q_W-1:0]     q0;
  logic               rem_zero;
  logic [Q_W-1:0]     c100;
  logic [Q_W-1:0]     c400;
  logic               leap;
  logic [DOY_W-1:0]   doy;
  logic [DN_W-1:0]    dn;

  always_comb begin
    y = cmd.second ? yr_b : yr_a;
    m = cmd.second ? mo_b : mo_a;
    d = cmd.second ? dy_b : dy_a;
    y_p3 = {1'b0, y} + (YEAR_W+1)'(3);
    // floor(y / 100) by reciprocal, exact for y below 25600 (q0 is 8 bits)
    q0 = prod[RECIP_SHIFT +: Q_W];
    rem_zero = (YEAR_W'(q0) * CENTURY) == y;
    c100 = q0 + Q_W'(!rem_zero);
    c400 = (c100 + Q_W'(3)) >> 2;
    leap = rem_zero ? (q0[1:0] == 2'b00) : (y[1:0] == 2'b00);
    doy = month_offset(m) + DOY_W'(leap && (m >= MARCH)) + DOY_W'(d);
    dn = base - DN_W'(c100) + DN_W'(c400) + DN_W'(doy);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      yr_a <= (first_year > MAX_YEAR) ? MAX_YEAR : first_year;
      mo_a <= first_month;
      dy_a <= first_day;
      yr_b <= (second_year > MAX_YEAR) ? MAX_YEAR : second_year;
      mo_b <= second_month;
      dy_b <= second_day;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(y) * PROD_W'(RECIP_100);
      base <= DN_W'(y) * DAYS_PER_YEAR + DN_W'(y_p3 >> 2);
    end
    if (cmd.sum && !cmd.second) begin
      dn_a <= dn;
    end
    if (cmd.sum && cmd.second) begin
      dn_b <= dn;
    end
    if (cmd.push) begin
      day_difference <= signed'(DIFF_W'(dn_a) - DIFF_W'(dn_b));
    end
  end

endmodule

`default_nettype wire

### design/dd_ctrl.sv
`default_nettype none

module dd_ctrl (
  input  wire           clk,
  input  wire           rst,
  input  dd_pkg::sts_t  sts,
  output dd_pkg::cmd_t  cmd,
  output logic          in_ready,
  output logic          out_valid
);
  import dd_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || sts.out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (sts.in_valid) state_next = ST_MUL_A;
      ST_MUL_A: state_next = ST_SUM_A;
      ST_SUM_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_SUM_B;
      ST_SUM_B: state_next = ST_PUSH;
      ST_PUSH:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = sts.in_valid;
      end
      ST_MUL_A: cmd.mul = 1'b1;
      ST_SUM_A: cmd.sum = 1'b1;
      ST_MUL_B: begin
        cmd.mul = 1'b1;
        cmd.second = 1'b1;
      end
      ST_SUM_B: begin
        cmd.sum = 1'b1;
        cmd.second = 1'b1;
      end
      ST_PUSH: cmd.push = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (sts.out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (sts.in_valid && in_ready) |=> state == ST_MUL_A)
    else $error("accepted beat did not start the year pass");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || sts.out_ready))
    else $error("result overwrote an untaken beat");

  a_push_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> out_valid)
    else $error("pushed result not presented");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul, cmd.sum, cmd.push}))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire

### design/date_difference_days.sv
// Signed day count between two Gregorian dates, first minus second.
// Input channel "dates" carries one beat per date pair (years 14 bits,
// saturated to 9999; month and day unchecked, counted linearly). Output
// channel "result" carries one beat per input beat: day_difference,
// 23-bit two's complement.
// Each date goes through a shared unit, a multiply step and then a sum step:
// a multiply by the reciprocal of 100 (plus 365*year), then the leap
// corrections and the day-of-year sum. A beat is taken in the idle state;
// the result is written to the output register in the push state, once both
// dates are summed, and only after that can a new beat be taken.
// When the receiver stalls, the held result stays valid; the next item is
// still accepted and computed, and waits in the last step until the
// output register frees.
// Reset (rst, synchronous) returns the controller to idle and drops the
// output valid; the datapath registers are not reset.
`default_nettype none

module date_difference_days (
  input wire       clk,
  input wire       rst,
  dd_in_if.sink    dates,
  dd_out_if.source result
);
  import dd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign sts.in_valid  = dates.valid;
  assign sts.out_ready = result.ready;

  dd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (dates.ready),
    .out_valid (result.valid)
  );

  dd_datapath u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .first_year     (dates.first_year),
    .first_month    (dates.first_month),
    .first_day      (dates.first_day),
    .second_year    (dates.second_year),
    .second_month   (dates.second_month),
    .second_day     (dates.second_day),
    .day_difference (result.day_difference)
  );

endmodule

`default_nettype wire

### test/tb_date_difference_days.sv
`default_nettype none

module tb_date_difference_days;
  import dd_pkg::*;

  localparam int LONG_HOLD   = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_N    = 100;
  localparam int MONTH_LEN [0:11] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
  } date_pair_t;

  logic clk = 1'b0;
  logic rst;

  dd_in_if  dates ();
  dd_out_if result ();

  date_difference_days dut (
    .clk    (clk),
    .rst    (rst),
    .dates  (dates),
    .result (result)
  );

  always #5 clk = ~clk;

  date_pair_t                pair_queue [$];
  logic signed [DIFF_W-1:0]  due_diffs [$];
  bit                        idle_on;
  bit                        long_hold_req;
  bit                        long_hold_done;
  int                        send_gap;
  int                        hold_left;
  int                        stall_cycles;
  int                        sent;
  int                        checked;
  int                        errors;
  int                        directed_n;

  function automatic longint day_count(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                                       logic [DAY_W-1:0] dy);
    longint y;
    longint total;
    bit     leap;
    y     = (yr > MAX_YEAR) ? longint'(MAX_YEAR) : longint'(yr);
    leap  = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    total = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int i = 0; i + 1 < int'(mo) && i < 12; i++) begin
      total += MONTH_LEN[i];
      if (i == 1 && leap) total += 1;
    end
    return total + longint'(dy);
  endfunction

  function automatic logic signed [DIFF_W-1:0] days_between(date_pair_t p);
    longint diff;
    diff = day_count(p.first_year, p.first_month, p.first_day)
         - day_count(p.second_year, p.second_month, p.second_day);
    if (diff > 4194303) diff = 4194303;
    if (diff < -4194304) diff = -4194304;
    return diff[DIFF_W-1:0];
  endfunction

  task automatic add_pair(int fy, int fm, int fd, int sy, int sm, int sd);
    date_pair_t p;
    p.first_year   = YEAR_W'(fy);
    p.first_month  = MONTH_W'(fm);
    p.first_day    = DAY_W'(fd);
    p.second_year  = YEAR_W'(sy);
    p.second_month = MONTH_W'(sm);
    p.second_day   = DAY_W'(sd);
    pair_queue.push_back(p);
  endtask

  function automatic logic [YEAR_W-1:0] rand_year();
    case ($urandom_range(0, 9))
      0: return YEAR_W'($urandom);
      1: return YEAR_W'($urandom_range(0, 99) * 100);
      default: return YEAR_W'($urandom_range(1, 9999));
    endcase
  endfunction

  function automatic logic [MONTH_W-1:0] rand_month();
    if ($urandom_range(0, 7) == 0) return MONTH_W'($urandom);
    return MONTH_W'($urandom_range(1, 12));
  endfunction

  function automatic logic [DAY_W-1:0] rand_day();
    if ($urandom_range(0, 7) == 0) return DAY_W'($urandom);
    return DAY_W'($urandom_range(1, 31));
  endfunction

  function automatic date_pair_t rand_pair();
    date_pair_t p;
    p.first_year   = rand_year();
    p.first_month  = rand_month();
    p.first_day    = rand_day();
    p.second_year  = rand_year();
    p.second_month = rand_month();
    p.second_day   = rand_day();
    // nearby dates exercise small differences and month/leap boundaries
    if ($urandom_range(0, 2) == 0)
      p.second_year = p.first_year + YEAR_W'($urandom_range(0, 2)) - YEAR_W'(1);
    return p;
  endfunction

  // driver
  always @(posedge clk) begin : drive_dates
    date_pair_t nxt;
    date_pair_t cur;
    if (rst) begin
      dates.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (dates.valid && dates.ready) begin
        cur.first_year   = dates.first_year;
        cur.first_month  = dates.first_month;
        cur.first_day    = dates.first_day;
        cur.second_year  = dates.second_year;
        cur.second_month = dates.second_month;
        cur.second_day   = dates.second_day;
        due_diffs.push_back(days_between(cur));
        sent++;
      end
      if (!dates.valid || dates.ready) begin
        if (send_gap != 0) begin
          dates.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (pair_queue.size() != 0) begin
          nxt = pair_queue.pop_front();
          dates.first_year   <= nxt.first_year;
          dates.first_month  <= nxt.first_month;
          dates.first_day    <= nxt.first_day;
          dates.second_year  <= nxt.second_year;
          dates.second_month <= nxt.second_month;
          dates.second_day   <= nxt.second_day;
          dates.valid        <= 1'b1;
          if (idle_on && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 9);
        end else begin
          dates.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_result
    logic signed [DIFF_W-1:0] want;
    if (rst) begin
      result.ready   <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        checked++;
        if (due_diffs.size() == 0) begin
          if (errors < 10) $display("unexpected result beat: %0d", result.day_difference);
          errors++;
        end else begin
          want = due_diffs.pop_front();
          if (result.day_difference !== want) begin
            if (errors < 10)
              $display("day_difference mismatch: expected %0d, got %0d",
                       want, result.day_difference);
            errors++;
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        result.ready   <= 1'b0;
        hold_left      <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else if (hold_left != 0) begin
        result.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result.ready <= 1'b0;
        hold_left    <= $urandom_range(0, 8);
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (dates.valid && dates.ready) || (result.valid && result.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst                = 1'b1;
    dates.valid        = 1'b0;
    dates.first_year   = '0;
    dates.first_month  = '0;
    dates.first_day    = '0;
    dates.second_year  = '0;
    dates.second_month = '0;
    dates.second_day   = '0;
    result.ready       = 1'b0;
    idle_on            = 1'b0;
    long_hold_req      = 1'b0;
    sent               = 0;
    checked            = 0;
    errors             = 0;
    stall_cycles       = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed beats
    add_pair(2000, 1, 1, 2000, 1, 1);
    add_pair(9999, 12, 31, 1, 1, 1);
    add_pair(1, 1, 1, 9999, 12, 31);
    add_pair(0, 0, 0, 16383, 15, 31);
    add_pair(16383, 15, 31, 0, 0, 0);
    add_pair(2000, 3, 1, 2000, 2, 28);
    add_pair(1900, 3, 1, 1900, 2, 28);
    add_pair(2004, 3, 1, 2004, 2, 28);
    add_pair(2100, 3, 1, 2100, 2, 28);
    add_pair(2023, 2, 31, 2023, 3, 3);   // day past month end
    add_pair(2023, 3, 0, 2023, 2, 28);   // day zero
    add_pair(2023, 0, 5, 2023, 1, 5);    // month zero
    add_pair(2023, 13, 1, 2024, 1, 1);   // month above twelve
    add_pair(2024, 15, 31, 2024, 12, 31);
    add_pair(0, 12, 31, 1, 1, 1);        // year zero
    add_pair(4, 3, 1, 0, 3, 1);
    add_pair(10000, 1, 1, 9999, 1, 1);   // year saturation
    add_pair(12345, 6, 15, 9999, 6, 15);
    add_pair(2024, 12, 31, 2024, 1, 1);
    add_pair(1, 1, 1, 1, 1, 2);
    add_pair(2000, 2, 29, 1999, 2, 28);
    add_pair(5000, 7, 4, 5000, 7, 5);
    directed_n = pair_queue.size();
    @(negedge clk);
    while (pair_queue.size() != 0 || dates.valid || due_diffs.size() != 0) @(negedge clk);

    // random beats with idling on both sides
    idle_on = 1'b1;
    for (int i = 0; i < RANDOM_N; i++) pair_queue.push_back(rand_pair());
    while (pair_queue.size() > 70) @(negedge clk);
    long_hold_req = 1'b1;
    while (pair_queue.size() > 25) @(negedge clk);
    idle_on = 1'b0;

    while (pair_queue.size() != 0 || dates.valid || due_diffs.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    errors += due_diffs.size();
    $display("date pairs sent: %0d (%0d directed), results checked: %0d, mismatches: %0d",
             sent, directed_n, checked, errors);
    $display("covered leap rules, year saturation, unchecked months and days, stalls");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
design/dd_pkg.sv
design/dd_in_if.sv
design/dd_out_if.sv
design/dd_datapath.sv
design/dd_ctrl.sv
design/date_difference_days.sv
test/tb_date_difference_days.sv
